// ===== src/c_like_source_tokenizer_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef C_LIKE_SOURCE_TOKENIZER_MACROS_SVH
`define C_LIKE_SOURCE_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication, checked out of reset.
`define CLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

// ===== src/cls_pkg.sv =====
// Types, token codes and character-class helpers for the tokenizer.
`default_nettype none
package cls_pkg;

    localparam int TEXT_LIMIT_DEF    = 256;
    localparam int POSITION_BITS_DEF = 24;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] source_byte;
    } src_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [23:0] line_number;
        logic [15:0] column_number;
        logic [23:0] start_offset;
        logic [7:0]  text_length;
        logic        error_flag;
        logic [15:0] error_total;
        logic        last;
    } tok_t;

    typedef enum logic [3:0] {
        M_IDLE, M_OP, M_LINEC, M_BLOCK, M_BSTAR, M_IDENT,
        M_INTD, M_INTDOT, M_FRAC, M_STR, M_CHR, M_DONE
    } mode_t;

    typedef struct packed {
        mode_t          mode;
        logic [7:0]     held_byte;
        logic           held_valid;
        logic [23:0]    line;
        logic [15:0]    col;
        logic [23:0]    tsl;
        logic [15:0]    tsc;
        logic [7:0]     tlen;
        logic [8:0][7:0] kw;
        logic           esc;
        logic [15:0]    errs;
    } scan_state_t;

    localparam scan_state_t ST_RESET = '{
        mode: M_IDLE, held_byte: 8'd0, held_valid: 1'b0, line: 24'd1, col: 16'd1,
        tsl: 24'd1, tsc: 16'd1, tlen: 8'd0, kw: '0, esc: 1'b0, errs: 16'd0};

    // token kinds
    localparam logic [5:0] TK_END     = 6'd0;
    localparam logic [5:0] TK_IDENT   = 6'd1;
    localparam logic [5:0] TK_INT     = 6'd2;
    localparam logic [5:0] TK_FLOAT   = 6'd3;
    localparam logic [5:0] TK_STRING  = 6'd4;
    localparam logic [5:0] TK_CHAR    = 6'd5;
    localparam logic [5:0] TK_KW_BASE = 6'd6;
    localparam logic [5:0] TK_PLUS    = 6'd25;
    localparam logic [5:0] TK_MINUS   = 6'd26;
    localparam logic [5:0] TK_STAR    = 6'd27;
    localparam logic [5:0] TK_SLASH   = 6'd28;
    localparam logic [5:0] TK_PCT     = 6'd29;
    localparam logic [5:0] TK_EQEQ    = 6'd30;
    localparam logic [5:0] TK_NE      = 6'd31;
    localparam logic [5:0] TK_LT      = 6'd32;
    localparam logic [5:0] TK_LE      = 6'd33;
    localparam logic [5:0] TK_GT      = 6'd34;
    localparam logic [5:0] TK_GE      = 6'd35;
    localparam logic [5:0] TK_ANDAND  = 6'd36;
    localparam logic [5:0] TK_OROR    = 6'd37;
    localparam logic [5:0] TK_NOT     = 6'd38;
    localparam logic [5:0] TK_ASSIGN  = 6'd39;
    localparam logic [5:0] TK_ADDEQ   = 6'd40;
    localparam logic [5:0] TK_SUBEQ   = 6'd41;
    localparam logic [5:0] TK_MULEQ   = 6'd42;
    localparam logic [5:0] TK_DIVEQ   = 6'd43;
    localparam logic [5:0] TK_MODEQ   = 6'd44;
    localparam logic [5:0] TK_INC     = 6'd45;
    localparam logic [5:0] TK_DEC     = 6'd46;
    localparam logic [5:0] TK_AMP     = 6'd47;
    localparam logic [5:0] TK_BAR     = 6'd48;
    localparam logic [5:0] TK_CARET   = 6'd49;
    localparam logic [5:0] TK_TILDE   = 6'd50;
    localparam logic [5:0] TK_SHL     = 6'd51;
    localparam logic [5:0] TK_SHR     = 6'd52;
    localparam logic [5:0] TK_LPAREN  = 6'd53;
    localparam logic [5:0] TK_RPAREN  = 6'd54;
    localparam logic [5:0] TK_LBRACE  = 6'd55;
    localparam logic [5:0] TK_RBRACE  = 6'd56;
    localparam logic [5:0] TK_LBRACK  = 6'd57;
    localparam logic [5:0] TK_RBRACK  = 6'd58;
    localparam logic [5:0] TK_COMMA   = 6'd59;
    localparam logic [5:0] TK_DOT     = 6'd60;
    localparam logic [5:0] TK_COLON   = 6'd61;
    localparam logic [5:0] TK_SEMI    = 6'd62;
    localparam logic [5:0] TK_INVALID = 6'd63;

    localparam int KW_COUNT = 19;

    // right-justified text, first character in the highest used byte
    localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
        "true", "false", "int", "float", "string", "bool", "char", "if",
        "else", "switch", "case", "default", "while", "for", "do", "break",
        "continue", "function", "return"};
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd5, 4'd3, 4'd5, 4'd6, 4'd4, 4'd4, 4'd2, 4'd4, 4'd6,
        4'd4, 4'd7, 4'd5, 4'd3, 4'd2, 4'd5, 4'd8, 4'd8, 4'd6};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic [5:0] kw_kind(input logic [8:0][7:0] kw_v,
                                            input logic [7:0] len);
        logic [5:0] kind;
        logic       hit;
        kind = TK_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = (len == {4'd0, KW_LEN[k]});
            for (int i = 0; i < 8; i++) begin
                if ((i < int'(KW_LEN[k])) &&
                    (kw_v[i] != KW_TEXT[k][(int'(KW_LEN[k]) - 1 - i) * 8 +: 8]))
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                kind = TK_KW_BASE + 6'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic [5:0] op_single(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            "+":     k = TK_PLUS;
            "-":     k = TK_MINUS;
            "*":     k = TK_STAR;
            "/":     k = TK_SLASH;
            "%":     k = TK_PCT;
            "<":     k = TK_LT;
            ">":     k = TK_GT;
            "!":     k = TK_NOT;
            "=":     k = TK_ASSIGN;
            "&":     k = TK_AMP;
            "|":     k = TK_BAR;
            default: k = TK_INVALID;
        endcase
        return k;
    endfunction

    // TK_END means no pair
    function automatic logic [5:0] op_pair(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] k;
        k = TK_END;
        if (b == "=")
        begin
            case (a)
                "=":     k = TK_EQEQ;
                "!":     k = TK_NE;
                "<":     k = TK_LE;
                ">":     k = TK_GE;
                "+":     k = TK_ADDEQ;
                "-":     k = TK_SUBEQ;
                "*":     k = TK_MULEQ;
                "/":     k = TK_DIVEQ;
                "%":     k = TK_MODEQ;
                default: k = TK_END;
            endcase
        end
        else if (a == b)
        begin
            case (a)
                "&":     k = TK_ANDAND;
                "|":     k = TK_OROR;
                "+":     k = TK_INC;
                "-":     k = TK_DEC;
                "<":     k = TK_SHL;
                ">":     k = TK_SHR;
                default: k = TK_END;
            endcase
        end
        return k;
    endfunction

    // TK_END means not punctuation
    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "^":     k = TK_CARET;
            "~":     k = TK_TILDE;
            "(":     k = TK_LPAREN;
            ")":     k = TK_RPAREN;
            "{":     k = TK_LBRACE;
            "}":     k = TK_RBRACE;
            "[":     k = TK_LBRACK;
            "]":     k = TK_RBRACK;
            ",":     k = TK_COMMA;
            ".":     k = TK_DOT;
            ":":     k = TK_COLON;
            ";":     k = TK_SEMI;
            default: k = TK_END;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== src/cls_scan.sv =====
// Single-pass scanner step: next state and up to three tokens for one beat.
`default_nettype none
module cls_scan
    import cls_pkg::*;
#(
    parameter int TEXT_LIMIT    = TEXT_LIMIT_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  src_t                     src,
    input  scan_state_t              st,
    input  logic [POSITION_BITS-1:0] pos,
    input  logic [POSITION_BITS-1:0] tsp,
    output scan_state_t              st_next,
    output logic [POSITION_BITS-1:0] pos_next,
    output logic [POSITION_BITS-1:0] tsp_next,
    output tok_t [2:0]               toks,
    output logic [1:0]               tok_count
);

    localparam int         LEN_CAP   = (TEXT_LIMIT - 1 < 255) ? TEXT_LIMIT - 1 : 255;
    localparam logic [7:0] LEN_CAP_V = 8'(LEN_CAP);

    logic [7:0] c;
    logic       go;
    logic       lit;
    logic       a_en, a_err, d_en, s_en, s_err, e_en;
    logic [5:0] a_kind, s_kind;
    logic [7:0] a_len, s_len;

    assign c = src.source_byte;

    // next state
    always_comb
    begin
        st_next  = st;
        pos_next = pos;
        tsp_next = tsp;
        go     = 1'b0;
        lit    = 1'b0;
        a_en   = 1'b0;
        a_err  = 1'b0;
        a_kind = TK_END;
        a_len  = st.tlen;
        d_en   = 1'b0;
        s_en   = 1'b0;
        s_err  = 1'b0;
        s_kind = TK_END;
        s_len  = 8'd1;
        e_en   = 1'b0;

        if (src.command == CMD_START)
        begin
            st_next  = ST_RESET;
            pos_next = '0;
            tsp_next = '0;
        end
        else if (src.command == CMD_NONE)
        begin
            st_next = st;
        end
        else if ((src.command == CMD_END) || (c == 8'd0))
        begin
            // flush any open token, then the end token
            unique case (st.mode)
                M_OP:
                begin
                    a_en   = 1'b1;
                    a_kind = op_single(st.held_byte);
                    a_len  = 8'd1;
                end
                M_IDENT:
                begin
                    a_en   = 1'b1;
                    a_kind = kw_kind(st.kw, st.tlen);
                end
                M_INTD:
                begin
                    a_en   = 1'b1;
                    a_kind = TK_INT;
                end
                M_INTDOT:
                begin
                    a_en   = 1'b1;
                    a_kind = TK_INT;
                    d_en   = 1'b1;
                end
                M_FRAC:
                begin
                    a_en   = 1'b1;
                    a_kind = TK_FLOAT;
                end
                M_STR, M_CHR:
                begin
                    a_en   = 1'b1;
                    a_err  = 1'b1;
                    a_kind = (st.mode == M_STR) ? TK_STRING : TK_CHAR;
                    if (st.errs != 16'hFFFF)
                    begin
                        st_next.errs = st.errs + 16'd1;
                    end
                end
                default:
                begin
                    a_en = 1'b0;
                end
            endcase
            e_en               = 1'b1;
            st_next.mode       = M_DONE;
            st_next.held_valid = 1'b0;
            st_next.esc        = 1'b0;
        end
        else if (st.mode != M_DONE)
        begin
            unique case (st.mode)
                M_IDLE:
                begin
                    go = 1'b1;
                end
                M_OP:
                begin
                    st_next.held_valid = 1'b0;
                    if ((st.held_byte == "/") && (c == "/"))
                    begin
                        st_next.mode = M_LINEC;
                    end
                    else if ((st.held_byte == "/") && (c == "*"))
                    begin
                        st_next.mode = M_BLOCK;
                    end
                    else
                    begin
                        st_next.mode = M_IDLE;
                        a_en = 1'b1;
                        if (op_pair(st.held_byte, c) != TK_END)
                        begin
                            a_kind = op_pair(st.held_byte, c);
                            a_len  = 8'd2;
                        end
                        else
                        begin
                            a_kind = op_single(st.held_byte);
                            a_len  = 8'd1;
                            go     = 1'b1;
                        end
                    end
                end
                M_LINEC:
                begin
                    if (c == "\n")
                    begin
                        st_next.mode = M_IDLE;
                        go = 1'b1;
                    end
                end
                M_BLOCK:
                begin
                    if (c == "*")
                    begin
                        st_next.mode = M_BSTAR;
                    end
                end
                M_BSTAR:
                begin
                    if (c == "/")
                    begin
                        st_next.mode = M_IDLE;
                    end
                    else if (c != "*")
                    begin
                        st_next.mode = M_BLOCK;
                    end
                end
                M_IDENT:
                begin
                    if (is_word(c))
                    begin
                        if (st_next.tlen < LEN_CAP_V)
                        begin
                            if (st_next.tlen < 8'd9)
                            begin
                                st_next.kw[st_next.tlen[3:0]] = c;
                            end
                            st_next.tlen = st_next.tlen + 8'd1;
                        end
                    end
                    else
                    begin
                        a_en   = 1'b1;
                        a_kind = kw_kind(st.kw, st.tlen);
                        st_next.mode = M_IDLE;
                        go = 1'b1;
                    end
                end
                M_INTD:
                begin
                    if (is_digit(c))
                    begin
                        if (st_next.tlen < LEN_CAP_V)
                        begin
                            if (st_next.tlen < 8'd9)
                            begin
                                st_next.kw[st_next.tlen[3:0]] = c;
                            end
                            st_next.tlen = st_next.tlen + 8'd1;
                        end
                    end
                    else if (c == ".")
                    begin
                        st_next.held_byte  = ".";
                        st_next.held_valid = (st.col != 16'hFFFF);
                        st_next.mode       = M_INTDOT;
                    end
                    else
                    begin
                        a_en   = 1'b1;
                        a_kind = TK_INT;
                        st_next.mode = M_IDLE;
                        go = 1'b1;
                    end
                end
                M_INTDOT:
                begin
                    if (is_digit(c))
                    begin
                        if (st_next.tlen < LEN_CAP_V)
                        begin
                            if (st_next.tlen < 8'd9)
                            begin
                                st_next.kw[st_next.tlen[3:0]] = ".";
                            end
                            st_next.tlen = st_next.tlen + 8'd1;
                        end
                        if (st_next.tlen < LEN_CAP_V)
                        begin
                            if (st_next.tlen < 8'd9)
                            begin
                                st_next.kw[st_next.tlen[3:0]] = c;
                            end
                            st_next.tlen = st_next.tlen + 8'd1;
                        end
                        st_next.held_valid = 1'b0;
                        st_next.mode       = M_FRAC;
                    end
                    else
                    begin
                        a_en   = 1'b1;
                        a_kind = TK_INT;
                        d_en   = 1'b1;
                        st_next.held_valid = 1'b0;
                        st_next.mode = M_IDLE;
                        go = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (is_digit(c))
                    begin
                        if (st_next.tlen < LEN_CAP_V)
                        begin
                            if (st_next.tlen < 8'd9)
                            begin
                                st_next.kw[st_next.tlen[3:0]] = c;
                            end
                            st_next.tlen = st_next.tlen + 8'd1;
                        end
                    end
                    else
                    begin
                        a_en   = 1'b1;
                        a_kind = TK_FLOAT;
                        st_next.mode = M_IDLE;
                        go = 1'b1;
                    end
                end
                M_STR, M_CHR:
                begin
                    lit = 1'b1;
                    if (st.esc)
                    begin
                        st_next.esc = 1'b0;
                        if (st_next.tlen < LEN_CAP_V)
                        begin
                            if (st_next.tlen < 8'd9)
                            begin
                                st_next.kw[st_next.tlen[3:0]] = c;
                            end
                            st_next.tlen = st_next.tlen + 8'd1;
                        end
                    end
                    else if (c == ((st.mode == M_STR) ? 8'("\"") : 8'("'")))
                    begin
                        a_en   = 1'b1;
                        a_kind = (st.mode == M_STR) ? TK_STRING : TK_CHAR;
                        st_next.mode = M_IDLE;
                    end
                    else
                    begin
                        if (c == "\\")
                        begin
                            st_next.esc = 1'b1;
                        end
                        if (st_next.tlen < LEN_CAP_V)
                        begin
                            if (st_next.tlen < 8'd9)
                            begin
                                st_next.kw[st_next.tlen[3:0]] = c;
                            end
                            st_next.tlen = st_next.tlen + 8'd1;
                        end
                    end
                end
                default:
                begin
                    st_next.mode = M_IDLE;
                    go = 1'b1;
                end
            endcase

            // first byte of a token, seen from the idle state
            if (go)
            begin
                if ((c == " ") || (c == "\t") || (c == "\r") || (c == "\n"))
                begin
                    st_next.mode = M_IDLE;
                end
                else if (is_alpha(c) || (c == "_") || is_digit(c))
                begin
                    st_next.tsl   = st.line;
                    st_next.tsc   = st.col;
                    tsp_next      = pos;
                    st_next.tlen  = 8'd1;
                    st_next.kw[0] = c;
                    st_next.mode  = is_digit(c) ? M_INTD : M_IDENT;
                end
                else if ((c == "\"") || (c == "'"))
                begin
                    st_next.tsl  = st.line;
                    st_next.tsc  = st.col;
                    tsp_next     = pos + 1'b1;
                    st_next.tlen = 8'd0;
                    st_next.esc  = 1'b0;
                    st_next.mode = (c == "\"") ? M_STR : M_CHR;
                end
                else if (op_single(c) != TK_INVALID)
                begin
                    st_next.tsl        = st.line;
                    st_next.tsc        = st.col;
                    tsp_next           = pos;
                    st_next.tlen       = 8'd0;
                    st_next.held_byte  = c;
                    st_next.held_valid = 1'b1;
                    st_next.mode       = M_OP;
                end
                else if (punct_kind(c) != TK_END)
                begin
                    s_en   = 1'b1;
                    s_kind = punct_kind(c);
                    st_next.mode = M_IDLE;
                end
                else
                begin
                    s_en   = 1'b1;
                    s_err  = 1'b1;
                    s_kind = TK_INVALID;
                    s_len  = 8'd0;
                    st_next.mode = M_IDLE;
                    if (st.errs != 16'hFFFF)
                    begin
                        st_next.errs = st.errs + 16'd1;
                    end
                end
            end

            pos_next = pos + 1'b1;
            if ((c == "\n") && !lit)
            begin
                if (st.line != 24'hFFFFFF)
                begin
                    st_next.line = st.line + 24'd1;
                end
                st_next.col = 16'd1;
            end
            else if (st.col != 16'hFFFF)
            begin
                st_next.col = st.col + 16'd1;
            end
        end
    end

    // token records, packed in emission order
    always_comb
    begin
        tok_t       rec_a, rec_d, rec_s, rec_e;
        logic [1:0] n;

        rec_a = '{token_kind: a_kind, line_number: st.tsl, column_number: st.tsc,
                  start_offset: 24'(tsp), text_length: a_len, error_flag: a_err,
                  error_total: a_err ? st_next.errs : st.errs, last: 1'b0};
        rec_d = '{token_kind: TK_DOT, line_number: st.line,
                  column_number: st.held_valid ? st.col - 16'd1 : st.col,
                  start_offset: 24'(pos - 1'b1), text_length: 8'd1, error_flag: 1'b0,
                  error_total: st.errs, last: 1'b0};
        rec_s = '{token_kind: s_kind, line_number: st.line, column_number: st.col,
                  start_offset: 24'(pos), text_length: s_len, error_flag: s_err,
                  error_total: st_next.errs, last: 1'b0};
        rec_e = '{token_kind: TK_END, line_number: st.line, column_number: st.col,
                  start_offset: 24'(pos), text_length: 8'd0, error_flag: 1'b0,
                  error_total: st_next.errs, last: 1'b0};

        toks = '0;
        n    = 2'd0;
        if (a_en)
        begin
            toks[n] = rec_a;
            n = n + 2'd1;
        end
        if (d_en)
        begin
            toks[n] = rec_d;
            n = n + 2'd1;
        end
        if (s_en)
        begin
            toks[n] = rec_s;
            n = n + 2'd1;
        end
        if (e_en)
        begin
            toks[n] = rec_e;
            n = n + 2'd1;
        end
        if (n != 2'd0)
        begin
            toks[n - 2'd1].last = 1'b1;
        end
        tok_count = n;
    end

endmodule
`default_nettype wire

// ===== src/c_like_source_tokenizer.sv =====
// Top level of the streaming C-like source tokenizer.
// Source bytes come in one beat at a time on the src channel and tokens leave on the tok
// channel. Each beat's scan step is a single combinational pass over the registered scanner
// state; the tokens it causes (none, or one to three) are captured in a three-entry result
// register that is drained one token per cycle while tok_ready is high; this register sets
// the rate. A beat with at most one token does not hold off the next, so plain source
// streams at one byte per cycle under the same condition; a beat that yields k tokens holds
// src_ready low until the last of them is taken. A word, number or operator token is
// reported when the byte after it arrives (one byte of lookahead); command 1, or a zero
// byte, flushes the open token and emits an end token, and after that bytes are dropped
// until command 2 clears all counters. Start columns and offsets of literals refer to the
// opening quote and the first byte inside it respectively.
`default_nettype none
`include "c_like_source_tokenizer_macros.svh"
module c_like_source_tokenizer
    import cls_pkg::*;
#(
    parameter int TEXT_LIMIT    = TEXT_LIMIT_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic src_valid,
    output logic src_ready,
    input  src_t src_data,
    output logic tok_valid,
    input  logic tok_ready,
    output tok_t tok_data
);

    scan_state_t              state_reg, state_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] tsp_reg, tsp_next;
    tok_t [2:0]               res_reg;
    tok_t [2:0]               res_next;
    logic [1:0]               rem_reg;
    logic [1:0]               res_count;
    logic                     src_fire, tok_fire;

    cls_scan #(
        .TEXT_LIMIT    (TEXT_LIMIT),
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .src       (src_data),
        .st        (state_reg),
        .pos       (pos_reg),
        .tsp       (tsp_reg),
        .st_next   (state_next),
        .pos_next  (pos_next),
        .tsp_next  (tsp_next),
        .toks      (res_next),
        .tok_count (res_count)
    );

    // Take a new beat when the result register is empty or its final token leaves now.
    assign src_ready = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && tok_ready);
    assign src_fire  = src_valid && src_ready;
    assign tok_valid = (rem_reg != 2'd0);
    assign tok_fire  = tok_valid && tok_ready;
    assign tok_data  = res_reg[0];

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RESET;
            pos_reg   <= '0;
            tsp_reg   <= '0;
        end
        else if (src_fire)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            tsp_reg   <= tsp_next;
        end
    end

    // result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
        end
        else if (src_fire)
        begin
            rem_reg <= res_count;
        end
        else if (tok_fire)
        begin
            rem_reg <= rem_reg - 2'd1;
        end
    end

    // result payload: load on a new beat, shift down as tokens leave
    always_ff @(posedge clk)
    begin
        if (src_fire)
        begin
            res_reg <= res_next;
        end
        else if (tok_fire)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    `CLS_ASSERT_IMP(a_no_overwrite, clk, rst_n, src_fire,
        (rem_reg == 2'd0) || ((rem_reg == 2'd1) && tok_fire))
    `CLS_ASSERT_IMP(a_last_on_final, clk, rst_n, tok_valid && (rem_reg == 2'd1),
        tok_data.last)
    `CLS_ASSERT_IMP(a_no_early_last, clk, rst_n, tok_valid && (rem_reg != 2'd1),
        !tok_data.last)
    `CLS_ASSERT_IMP(a_done_no_held, clk, rst_n, state_reg.mode == M_DONE,
        !state_reg.held_valid && !state_reg.esc)
    `CLS_ASSERT_NXT(a_errs_monotonic, clk, rst_n,
        !(src_fire && (src_data.command == CMD_START)),
        state_reg.errs >= $past(state_reg.errs))

endmodule
`default_nettype wire

// ===== bench/tb_c_like_source_tokenizer.sv =====
// Self-checking testbench for the streaming C-like source tokenizer.
`timescale 1ns / 100ps
`default_nettype none

module tb_c_like_source_tokenizer;
    import cls_pkg::*;

    // Scanner modes of the bench's own predictor
    typedef enum int
    {
        S_IDLE, S_OP, S_LINEC, S_BLOCK, S_BSTAR, S_IDENT,
        S_INTD, S_INTDOT, S_FRAC, S_STR, S_CHR, S_DONE
    } scan_t;

    // Token store: holds predicted tokens in order and checks beats against them
    class token_board;
        tok_t pending[$];
        int   mismatches;

        function void note(input tok_t t);
            pending.push_back(t);
        endfunction

        // One line per mismatch, and count it
        task report(input string msg);
            $display("%s", msg);
            mismatches++;
        endtask

        task check(input tok_t got);
            tok_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected token kind=%0d line=%0d col=%0d",
                                 got.token_kind, got.line_number, got.column_number));
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                report($sformatf("token mismatch: got %h want %h", got, want));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic src_valid;
    logic src_ready;
    src_t src_data;
    logic tok_valid;
    logic tok_ready;
    tok_t tok_data;

    token_board board;
    int         send_idle_pct;
    int         stall_pct;
    int         leftover_errors;

    // Predictor state
    scan_t       md;
    logic [7:0]  hb;
    logic        hv;
    logic [23:0] bpos;
    logic [23:0] ln;
    logic [15:0] cl;
    logic [23:0] t_pos;
    logic [23:0] t_ln;
    logic [15:0] t_cl;
    logic [7:0]  t_len;
    logic [7:0]  kwbuf [9];
    logic        esc;
    logic [15:0] errs;
    tok_t        step_out [$];

    c_like_source_tokenizer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_data  (tok_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #4000000;
        $display("tb_c_like_source_tokenizer: FAIL");
        $finish;
    end

    function automatic logic dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic alph(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic wordc(input logic [7:0] c);
        return alph(c) || dig(c) || c == "_";
    endfunction

    function automatic logic [5:0] single_op(input logic [7:0] b);
        case (b)
            "+": return TK_PLUS;
            "-": return TK_MINUS;
            "*": return TK_STAR;
            "/": return TK_SLASH;
            "%": return TK_PCT;
            "<": return TK_LT;
            ">": return TK_GT;
            "!": return TK_NOT;
            "=": return TK_ASSIGN;
            "&": return TK_AMP;
            "|": return TK_BAR;
            default: return TK_INVALID;
        endcase
    endfunction

    function automatic logic [5:0] pair_op(input logic [7:0] a, input logic [7:0] b);
        if (b == "=")
        begin
            case (a)
                "=": return TK_EQEQ;
                "!": return TK_NE;
                "<": return TK_LE;
                ">": return TK_GE;
                "+": return TK_ADDEQ;
                "-": return TK_SUBEQ;
                "*": return TK_MULEQ;
                "/": return TK_DIVEQ;
                "%": return TK_MODEQ;
                default: return TK_END;
            endcase
        end
        if (a == b)
        begin
            case (a)
                "&": return TK_ANDAND;
                "|": return TK_OROR;
                "+": return TK_INC;
                "-": return TK_DEC;
                "<": return TK_SHL;
                ">": return TK_SHR;
                default: return TK_END;
            endcase
        end
        return TK_END;
    endfunction

    function automatic logic [5:0] punct(input logic [7:0] c);
        case (c)
            "^": return TK_CARET;
            "~": return TK_TILDE;
            "(": return TK_LPAREN;
            ")": return TK_RPAREN;
            "{": return TK_LBRACE;
            "}": return TK_RBRACE;
            "[": return TK_LBRACK;
            "]": return TK_RBRACK;
            ",": return TK_COMMA;
            ".": return TK_DOT;
            ":": return TK_COLON;
            ";": return TK_SEMI;
            default: return TK_END;
        endcase
    endfunction

    // Keyword lookup on the held identifier text
    function automatic logic [5:0] word_kind();
        string words [19];
        string w;
        logic  hit;
        words = '{"true", "false", "int", "float", "string", "bool", "char", "if",
                  "else", "switch", "case", "default", "while", "for", "do", "break",
                  "continue", "function", "return"};
        for (int k = 0; k < 19; k++)
        begin
            w = words[k];
            if (w.len() != int'(t_len))
                continue;
            hit = 1'b1;
            for (int i = 0; i < w.len(); i++)
                if (kwbuf[i] != w[i])
                    hit = 1'b0;
            if (hit)
                return TK_KW_BASE + 6'(k);
        end
        return TK_IDENT;
    endfunction

    task automatic clear_scan();
        md = S_IDLE; hb = 0; hv = 0; bpos = 0; ln = 1; cl = 1;
        t_pos = 0; t_ln = 1; t_cl = 1; t_len = 0; esc = 0; errs = 0;
        for (int i = 0; i < 9; i++)
            kwbuf[i] = 8'd0;
    endtask

    task automatic put(input logic [5:0] k, input logic [23:0] l, input logic [15:0] c,
                       input logic [23:0] p, input logic [7:0] n, input logic e);
        tok_t t;
        t.token_kind = k; t.line_number = l; t.column_number = c;
        t.start_offset = p; t.text_length = n; t.error_flag = e;
        t.error_total = errs; t.last = 1'b0;
        step_out.push_back(t);
    endtask

    task automatic put_open(input logic [5:0] k, input logic e);
        put(k, t_ln, t_cl, t_pos, t_len, e);
    endtask

    task automatic bump_errors();
        if (errs != 16'hFFFF)
            errs++;
    endtask

    task automatic add_char(input logic [7:0] c);
        if (t_len < 8'd255)
        begin
            if (t_len < 9)
                kwbuf[t_len] = c;
            t_len++;
        end
    endtask

    task automatic open_tok(input logic [23:0] l, input logic [15:0] c, input logic [23:0] p);
        t_ln = l; t_cl = c; t_pos = p; t_len = 0;
    endtask

    // Integer followed by a dot: the dot sits one byte back
    task automatic put_int_dot(input logic [23:0] l, input logic [15:0] c,
                               input logic [23:0] p);
        put_open(TK_INT, 1'b0);
        put(TK_DOT, l, hv ? c - 16'd1 : c, p - 24'd1, 8'd1, 1'b0);
        hv = 0;
    endtask

    task automatic first_byte(input logic [7:0] c, input logic [23:0] l,
                              input logic [15:0] cc, input logic [23:0] p);
        if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A)
            return;
        if (alph(c) || c == "_")
        begin
            open_tok(l, cc, p); add_char(c); md = S_IDENT;
        end
        else if (dig(c))
        begin
            open_tok(l, cc, p); add_char(c); md = S_INTD;
        end
        else if (c == "\"" || c == "'")
        begin
            open_tok(l, cc, p + 24'd1); esc = 0;
            md = (c == "\"") ? S_STR : S_CHR;
        end
        else if (single_op(c) != TK_INVALID)
        begin
            open_tok(l, cc, p); hb = c; hv = 1; md = S_OP;
        end
        else if (punct(c) != TK_END)
            put(punct(c), l, cc, p, 8'd1, 1'b0);
        else
        begin
            bump_errors();
            put(TK_INVALID, l, cc, p, 8'd0, 1'b1);
        end
    endtask

    // Predicts the tokens of one accepted beat into step_out
    task automatic predict_step(input src_t s);
        logic [7:0]  c;
        logic [23:0] l;
        logic [15:0] cc;
        logic [23:0] p;
        logic        again;
        logic        lit;
        logic [5:0]  k;
        c = s.source_byte;
        step_out.delete();
        lit = 0;
        if (s.command == CMD_START)
        begin
            clear_scan();
            return;
        end
        if (s.command == CMD_NONE)
            return;
        if (s.command == CMD_END || c == 8'd0)
        begin
            case (md)
                S_OP:    put(single_op(hb), t_ln, t_cl, t_pos, 8'd1, 1'b0);
                S_IDENT: put_open(word_kind(), 1'b0);
                S_INTD:  put_open(TK_INT, 1'b0);
                S_INTDOT: put_int_dot(ln, cl, bpos);
                S_FRAC:  put_open(TK_FLOAT, 1'b0);
                S_STR, S_CHR:
                begin
                    bump_errors();
                    put_open(md == S_STR ? TK_STRING : TK_CHAR, 1'b1);
                end
                default: ;
            endcase
            put(TK_END, ln, cl, bpos, 8'd0, 1'b0);
            md = S_DONE; hv = 0; esc = 0;
            step_out[$].last = 1'b1;
            return;
        end
        if (md == S_DONE)
            return;
        l = ln; cc = cl; p = bpos;
        do
        begin
            again = 0;
            case (md)
                S_IDLE: first_byte(c, l, cc, p);
                S_OP:
                begin
                    hv = 0;
                    if (hb == "/" && c == "/")
                        md = S_LINEC;
                    else if (hb == "/" && c == "*")
                        md = S_BLOCK;
                    else
                    begin
                        k = pair_op(hb, c);
                        md = S_IDLE;
                        if (k != TK_END)
                            put(k, t_ln, t_cl, t_pos, 8'd2, 1'b0);
                        else
                        begin
                            put(single_op(hb), t_ln, t_cl, t_pos, 8'd1, 1'b0);
                            again = 1;
                        end
                    end
                end
                S_LINEC:
                    if (c == 8'h0A)
                    begin
                        md = S_IDLE; again = 1;
                    end
                S_BLOCK:
                    if (c == "*")
                        md = S_BSTAR;
                S_BSTAR:
                    if (c == "/")
                        md = S_IDLE;
                    else if (c != "*")
                        md = S_BLOCK;
                S_IDENT:
                    if (wordc(c))
                        add_char(c);
                    else
                    begin
                        put_open(word_kind(), 1'b0); md = S_IDLE; again = 1;
                    end
                S_INTD:
                    if (dig(c))
                        add_char(c);
                    else if (c == ".")
                    begin
                        hb = "."; hv = (cc != 16'hFFFF); md = S_INTDOT;
                    end
                    else
                    begin
                        put_open(TK_INT, 1'b0); md = S_IDLE; again = 1;
                    end
                S_INTDOT:
                    if (dig(c))
                    begin
                        add_char("."); add_char(c); hv = 0; md = S_FRAC;
                    end
                    else
                    begin
                        put_int_dot(l, cc, p); md = S_IDLE; again = 1;
                    end
                S_FRAC:
                    if (dig(c))
                        add_char(c);
                    else
                    begin
                        put_open(TK_FLOAT, 1'b0); md = S_IDLE; again = 1;
                    end
                S_STR, S_CHR:
                begin
                    lit = 1;
                    if (esc)
                    begin
                        esc = 0; add_char(c);
                    end
                    else if (c == (md == S_STR ? 8'h22 : 8'h27))
                    begin
                        put_open(md == S_STR ? TK_STRING : TK_CHAR, 1'b0);
                        md = S_IDLE;
                    end
                    else
                    begin
                        if (c == "\\")
                            esc = 1;
                        add_char(c);
                    end
                end
                default:
                begin
                    md = S_IDLE; again = 1;
                end
            endcase
        end
        while (again);
        bpos++;
        if (c == 8'h0A && !lit)
        begin
            if (ln != 24'hFFFFFF)
                ln++;
            cl = 1;
        end
        else if (cl != 16'hFFFF)
            cl++;
        if (step_out.size() > 0)
            step_out[$].last = 1'b1;
    endtask

    // Sends one beat, with random idle cycles ahead of it; valid stays up between
    // back-to-back beats
    task automatic send(input logic [1:0] cmd, input logic [7:0] b);
        src_t s;
        while ($urandom_range(99) < send_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        s.command = cmd;
        s.source_byte = b;
        src_valid <= 1'b1;
        src_data <= s;
        do
            @(posedge clk);
        while (!src_ready);
        predict_step(s);
        foreach (step_out[i])
            board.note(step_out[i]);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send(CMD_BYTE, txt[i]);
    endtask

    task automatic wait_drained();
        src_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // Picks a random fragment of plausible source
    task automatic random_fragment();
        string frags [24];
        frags = '{"int x = 12;\n", "a+=b", "c--", "x<<2 ", "y>=z;", "&& || ",
                  "\"str\\\"ing\" ", "'\\n'", "3.14 ", "7. ", "return foo(1,2);",
                  "// note\n", "/* blk ** */", "while(i!=0){i%=3;}", "[k]:~^ ",
                  "continue;", "function f", "default:", "switch", "true false",
                  "\"multi\nline\"", "a_b9 ", "case do for if else", "break char bool"};
        case ($urandom_range(9))
            0: send(CMD_BYTE, 8'($urandom_range(255)));
            1: send(CMD_BYTE, 8'($urandom_range(32, 126)));
            2: send(CMD_BYTE, 8'h0A);
            default: send_text(frags[$urandom_range(23)]);
        endcase
    endtask

    // Sink side: random stalls, every beat checked in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tok_valid && tok_ready)
                board.check(tok_data);
            tok_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        board = new();
        clear_scan();
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_data = '0;
        tok_ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: operators, keywords, numbers, literals, comments, bad bytes
        send_text("if(x<=9){y+=1.5;}\n");
        send_text("abc\t== != >= % ++ -- & | ! ~ ^ ,. :[] >> << -= *= /= %= ");
        send_text("continue 42. \"a\\\"b\" '\\'' /* c */ // l\n");
        send(CMD_BYTE, 8'h80);
        send(CMD_BYTE, 8'hFF);
        send(CMD_BYTE, "@");
        send_text("\"open");
        send(CMD_END, 8'h00);
        send(CMD_BYTE, "q");        // dropped after end
        send(CMD_END, 8'hFF);       // repeats end
        send(CMD_NONE, 8'h55);
        send(CMD_START, 8'hAA);
        send_text("12.");
        send(CMD_BYTE, 8'h00);      // zero byte acts as end
        send(CMD_START, 8'h00);
        send_text("'x/*");
        send(CMD_END, 8'h00);
        send(CMD_START, 8'h00);
        wait_drained();             // sender holds off until all tokens are out

        // Random phases with varying idle and stall rates
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 52 : 16) : 0;
            stall_pct = (ph == 2) ? 52 : ((ph == 3) ? 16 : 0);
            for (int n = 0; n < 5; n++)
                random_fragment();
            if ($urandom_range(1))
                send(CMD_END, 8'($urandom_range(255)));
            send(CMD_START, 8'($urandom_range(255)));
        end
        send_text("x");
        send(CMD_END, 8'h00);

        wait_drained();
        repeat (20) @(posedge clk);
        leftover_errors = board.mismatches;
        if (leftover_errors == 0)
            $display("tb_c_like_source_tokenizer: PASS");
        else
            $display("tb_c_like_source_tokenizer: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/cls_pkg.sv
src/cls_scan.sv
src/c_like_source_tokenizer.sv
bench/tb_c_like_source_tokenizer.sv
